### rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants of the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

	localparam int unsigned PATTERN_DEPTH_DEF = 64;
	localparam int unsigned NAME_DEPTH_DEF    = 64;

	// wildcard codes
	localparam logic [7:0] WILD_ONE = 8'h3F;
	localparam logic [7:0] WILD_RUN = 8'h2A;

	// classified request kinds
	typedef enum logic [1:0] {
		OP_PAT,
		OP_NAME,
		OP_NAME_LAST
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] code;
		logic       last;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### rtl/gwm_front.sv
// ----------------------------------------------------------------------------
// gwm_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_front import gwm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       command,
	input  wire logic [7:0] char_code,
	input  wire logic       last,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  wire logic       cmd_pop
);

	cmd_t        entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push_ok;
	logic        pop_ok;
	cmd_t        cls;

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;

	always_comb begin
		cls.code = char_code;
		cls.last = last;
		if (!command) begin
			cls.op = OP_PAT;
		end else if (last) begin
			cls.op = OP_NAME_LAST;
		end else begin
			cls.op = OP_NAME;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 2'd1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/gwm_back.sv
// ----------------------------------------------------------------------------
// gwm_back
// Keeps pattern and name buffers and runs the backtracking glob match.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_back import gwm_pkg::*; #(
	parameter int unsigned PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	parameter int unsigned NAME_DEPTH    = NAME_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      res_valid,
	input  wire logic res_pop,
	output logic      matched,
	output logic      overflow
);

	localparam int unsigned PAW = $clog2(PATTERN_DEPTH);
	localparam int unsigned PLW = $clog2(PATTERN_DEPTH + 1);
	localparam int unsigned NAW = $clog2(NAME_DEPTH);
	localparam int unsigned NLW = $clog2(NAME_DEPTH + 1);
	localparam logic [PLW-1:0] PDEPTH_L = PLW'(PATTERN_DEPTH);
	localparam logic [NLW-1:0] NDEPTH_L = NLW'(NAME_DEPTH);

	logic [7:0] pat_mem  [PATTERN_DEPTH];
	logic [7:0] name_mem [NAME_DEPTH];
	logic [7:0] pat_rd_q;
	logic [7:0] name_rd_q;

	state_t         state_q, state_d;
	logic [PLW-1:0] plen_q;
	logic           pclosed_q;
	logic           ptl_q;
	logic [NLW-1:0] nlen_q;
	logic           ntl_q;
	logic [PLW-1:0] p_q, sp_q;
	logic [NLW-1:0] n_q, sn_q;
	logic           star_q;
	logic           hit_q;
	logic           ovf_q;
	logic           res_valid_q;
	logic           matched_q;
	logic           overflow_q;

	logic [PLW-1:0] plen_eff;
	logic           ptl_eff;
	logic           pat_room;
	logic           name_room;
	logic           slot_free;
	logic           pat_we;
	logic           name_we;
	logic           res_load;
	logic           p_lt, n_lt, is_run, is_hit, ev_done;

	// a pattern request after a closed pattern starts a fresh one
	assign plen_eff  = pclosed_q ? '0 : plen_q;
	assign ptl_eff   = pclosed_q ? 1'b0 : ptl_q;
	assign pat_room  = (plen_eff < PDEPTH_L);
	assign name_room = (nlen_q < NDEPTH_L);
	assign slot_free = !res_valid_q || res_pop;

	assign p_lt    = (p_q < plen_q);
	assign n_lt    = (n_q < nlen_q);
	assign is_run  = p_lt && (pat_rd_q == WILD_RUN);
	assign is_hit  = p_lt && ((pat_rd_q == WILD_ONE) || (pat_rd_q == name_rd_q));
	assign ev_done = n_lt ? (!is_run && !is_hit && !star_q) : !is_run;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.op == OP_NAME_LAST) begin
					state_d = (ptl_q || ntl_q || !name_room) ? ST_DONE : ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: state_d = ev_done ? ST_DONE : ST_READ;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop  = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd_pop  = cmd_valid;
			ST_DONE: res_load = slot_free;
			default: ;
		endcase
		pat_we  = cmd_pop && (cmd.op == OP_PAT) && pat_room;
		name_we = cmd_pop && (cmd.op != OP_PAT) && name_room;
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[plen_eff[PAW-1:0]] <= cmd.code;
		end
		if (name_we) begin
			name_mem[nlen_q[NAW-1:0]] <= cmd.code;
		end
		pat_rd_q  <= pat_mem[p_q[PAW-1:0]];
		name_rd_q <= name_mem[n_q[NAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			plen_q    <= '0;
			pclosed_q <= 1'b1;
			ptl_q     <= 1'b0;
			nlen_q    <= '0;
			ntl_q     <= 1'b0;
			p_q       <= '0;
			n_q       <= '0;
			sp_q      <= '0;
			sn_q      <= '0;
			star_q    <= 1'b0;
			hit_q     <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							OP_PAT: begin
								plen_q    <= plen_eff + PLW'(pat_room);
								ptl_q     <= ptl_eff || !pat_room;
								pclosed_q <= cmd.last;
							end
							OP_NAME, OP_NAME_LAST: begin
								nlen_q <= nlen_q + NLW'(name_room);
								ntl_q  <= ntl_q || !name_room;
								if (cmd.op == OP_NAME_LAST) begin
									p_q    <= '0;
									n_q    <= '0;
									star_q <= 1'b0;
									hit_q  <= 1'b0;
									ovf_q  <= ptl_q || ntl_q || !name_room;
								end
							end
							default: ;
						endcase
					end
				end
				ST_EVAL: begin
					if (n_lt) begin
						if (is_run) begin
							star_q <= 1'b1;
							sp_q   <= p_q;
							sn_q   <= n_q;
							p_q    <= p_q + 1'b1;
						end else if (is_hit) begin
							p_q <= p_q + 1'b1;
							n_q <= n_q + 1'b1;
						end else if (star_q) begin
							// backtrack: the latest star takes one more char
							sn_q <= sn_q + 1'b1;
							n_q  <= sn_q + 1'b1;
							p_q  <= sp_q + 1'b1;
						end else begin
							hit_q <= 1'b0;
						end
					end else if (is_run) begin
						p_q <= p_q + 1'b1;
					end else begin
						hit_q <= (p_q == plen_q);
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						nlen_q <= '0;
						ntl_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			matched_q  <= hit_q && !ovf_q;
			overflow_q <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign matched   = matched_q;
	assign overflow  = overflow_q;

endmodule

`default_nettype wire

### rtl/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Glob matcher: loads a pattern, then matches each buffered name against it.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  request   in         push / full   command, char_code, last
//  result    out        pop / empty   matched, overflow
//
//  pattern chars and non-last name chars are stored by the back end straight from the queue.
//  a last name char starts the match walk; each of its S steps reads the buffers
//  (READ) and then evaluates (EVAL); S is up to about P*N with backtracking.
//  a two-entry request queue keeps taking requests while the back end works.
//  after reset both buffers are empty and the pattern is closed.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher import gwm_pkg::*; #(
	parameter int unsigned PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	parameter int unsigned NAME_DEPTH    = NAME_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       command,
	input  wire logic [7:0] char_code,
	input  wire logic       last,
	output logic            empty,
	input  wire logic       pop,
	output logic            matched,
	output logic            overflow
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic res_valid;

	gwm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.char_code (char_code),
		.last      (last),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	gwm_back #(
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.NAME_DEPTH    (NAME_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res_pop   (pop),
		.matched   (matched),
		.overflow  (overflow)
	);

	assign empty = !res_valid;

endmodule

`default_nettype wire

### rtl/gwm_checker.sv
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks of the glob wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic matched,
	input wire logic overflow
);

	// an overflowed name never reports a match
	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(matched && overflow))
		else $error("matched and overflow both set");

	// the request queue only fills on an accepted request
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a request");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped without pop");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(matched) && $stable(overflow))
		else $error("waiting result changed");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.matched  (matched),
	.overflow (overflow)
);

`default_nettype wire
